FILE: design/ust_pkg.sv
// Shared types, widths and saturating helpers for the upwind stencil builder.
// Used by ust_div, ust_mul, the top level and the checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

  localparam int DATA_W        = 32;            // Q15.F input word
  localparam int COEF_W        = 48;            // Q31.F coefficient
  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_W          = 2 * DATA_W - 1; // |beta|^2 fits here
  localparam int DEN_W         = 2 * DATA_W;    // widest divisor: dx+ * dx-
  localparam int S_DATA_W      = 3 * DATA_W;
  localparam int M_DATA_W      = 3 * COEF_W;
  localparam int WIDE_W        = COEF_W + 2;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {2'b00, COEF_MAX};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {2'b11, COEF_MIN};

  // Divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic              over;   // quotient ran past 2^COEF_W
    logic [COEF_W-1:0] quot;
  } div_res_t;

  function automatic logic signed [COEF_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = COEF_MAX;
    end else if (v < WIDE_MIN) begin
      r = COEF_MIN;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] add48(input logic signed [COEF_W-1:0] a,
                                                     input logic signed [COEF_W-1:0] b);
    logic signed [WIDE_W-1:0] s;
    s = WIDE_W'(a) + WIDE_W'(b);
    return sat48(s);
  endfunction

  function automatic logic signed [COEF_W-1:0] sub48(input logic signed [COEF_W-1:0] a,
                                                     input logic signed [COEF_W-1:0] b);
    logic signed [WIDE_W-1:0] s;
    s = WIDE_W'(a) - WIDE_W'(b);
    return sat48(s);
  endfunction

  // Apply the numerator sign to an unsigned quotient and saturate
  function automatic logic signed [COEF_W-1:0] qsat(input logic neg, input logic over,
                                                    input logic [COEF_W-1:0] quot);
    logic signed [COEF_W-1:0] r;
    if (!neg) begin
      r = (over || quot[COEF_W-1]) ? COEF_MAX : quot;
    end else if (over || (quot[COEF_W-1] && (|quot[COEF_W-2:0]))) begin
      r = COEF_MIN;
    end else begin
      r = -quot;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/ust_mul.sv
// Registered 32x32 unsigned multiplier shared for beta^2 and dx+ * dx-.
// Depends on ust_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module ust_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ust_pkg::DATA_W-1:0]    op_a,
  input  logic [ust_pkg::DATA_W-1:0]    op_b,
  output logic [2*ust_pkg::DATA_W-1:0]  prod
);
  import ust_pkg::*;

  logic [2*DATA_W-1:0] op_a_w, op_b_w;

  assign op_a_w = {{DATA_W{1'b0}}, op_a};
  assign op_b_w = {{DATA_W{1'b0}}, op_b};

  // hold the product until the next enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a_w * op_b_w;
    end
  end

endmodule

`default_nettype wire

FILE: design/ust_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, saturation flag.
// Depends on ust_pkg for widths and the div_res_t status struct.
`timescale 1ns / 1ps
`default_nettype none

module ust_div #(
  parameter  int FRAC_BITS = ust_pkg::FRAC_BITS_DEF,
  localparam int DVD_W     = ust_pkg::SQ_W + FRAC_BITS - 1,
  localparam int CNT_W     = $clog2(DVD_W + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,  // left aligned
  input  logic [CNT_W-1:0]           nbits,     // significant dividend bits
  input  logic [ust_pkg::DEN_W-1:0]  divisor,
  output ust_pkg::div_res_t          res
);
  import ust_pkg::*;

  logic [DVD_W-1:0]  dvd;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [COEF_W-1:0] quo;
  logic              over;
  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic              last_step;

  assign trial     = {rem, dvd[DVD_W-1]};
  assign ge        = trial >= {1'b0, den};
  assign last_step = busy && (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last_step;
      if (start) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quo  <= '0;
      over <= 1'b0;
      cnt  <= nbits;
    end else if (busy) begin
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      over <= over | quo[COEF_W-1];
      quo  <= {quo[COEF_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign res = '{done: done, over: over, quot: quo};

endmodule

`default_nettype wire

FILE: design/upwind_stencil_builder.sv
// Upwind convection-diffusion stencil builder: sequencer around a shared
// serial divider and a registered multiplier. Depends on ust_pkg, ust_div, ust_mul.
//
// Grid points enter on the s_ stream in increasing coordinate order, one
// transaction per point; s_tlast marks the final point. Stencils (a, b, c)
// leave on the m_ stream; m_tlast marks the final point's stencil and
// m_tuser flags a stencil that could not be formed (a = b = c = 0).
// A point's stencil leaves when the next point arrives; the final point
// yields two stencils, a lone final point yields one flagged stencil.
// One point is worked at a time and s_tready is low meanwhile. Quotients
// are formed one bit per cycle through the shared divider. A second point
// of a grid takes one division, an interior point two or three (three when
// it is upwinded), and a final point with valid spacing adds one more for
// its backward stencil. Synchronous reset empties the window and the output
// register and starts a new grid. A stalled receiver holds m_tdata; the
// sequencer waits in its push step, and a new point is taken while the last
// stencil is still held.
`timescale 1ns / 1ps
`default_nettype none

module upwind_stencil_builder #(
  parameter int FRAC_BITS = ust_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ust_pkg::S_DATA_W-1:0]  s_tdata,   // grid_x, drift, volatility
  input  logic                          s_tlast,   // final_point
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ust_pkg::M_DATA_W-1:0]  m_tdata,   // coef_lower, coef_centre, coef_upper
  output logic                          m_tlast,   // last_stencil
  output logic [0:0]                    m_tuser    // bad_grid
);
  import ust_pkg::*;

  localparam int DVD_W   = SQ_W + FRAC_BITS - 1;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int QD_BITS = DATA_W + FRAC_BITS;
  localparam int DX_W    = DATA_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV_F = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_PROD  = 4'd4;
  localparam logic [3:0] S_DIV_D = 4'd5;
  localparam logic [3:0] S_DIV_G = 4'd6;
  localparam logic [3:0] S_DIV_T = 4'd7;
  localparam logic [3:0] S_COMB  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_CHKL  = 4'd10;
  localparam logic [3:0] S_DIV_L = 4'd11;
  localparam logic [3:0] S_UPD   = 4'd12;

  localparam logic [1:0] PS_START = 2'd0;
  localparam logic [1:0] PS_FIRST = 2'd1;
  localparam logic [1:0] PS_INNER = 2'd2;

  localparam logic [1:0] DIR_CEN = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_BWD = 2'd2;

  logic [3:0] state;
  logic [3:0] after_push;
  logic       launched;
  logic [1:0] points_seen;

  logic signed [DATA_W-1:0] older_x, held_x, held_drift, held_vol;
  logic signed [DATA_W-1:0] in_x, in_al, in_be;
  logic                     in_fin;

  logic [SQ_W-1:0]          sq;
  logic signed [COEF_W-1:0] d_val, b0_val, g_val, t_val;
  logic [1:0]               dir;
  logic signed [COEF_W-1:0] r_a, r_b, r_c;
  logic                     r_last, r_bad;

  logic signed [DX_W-1:0]   dx_old, dx_new;
  logic [DX_W:0]            dx_sum;
  logic                     dx_old_ok, dx_new_ok;
  logic [DATA_W-1:0]        vol_mag;

  logic signed [DATA_W-1:0] num;
  logic                     num_neg;
  logic [DATA_W-1:0]        num_mag;
  logic                     use_sq;
  logic [DEN_W-1:0]         den_sel;
  logic [DVD_W-1:0]         dividend;
  logic [CNT_W-1:0]         nbits;
  logic                     div_state;
  logic                     div_start;
  div_res_t                 dres;
  logic signed [COEF_W-1:0] qv;
  logic signed [COEF_W-1:0] d_neg;
  logic                     push_go;

  logic                     mul_en;
  logic [DATA_W-1:0]        mul_a, mul_b;
  logic [DEN_W-1:0]         prod;

  assign s_tready = (state == S_IDLE);
  assign push_go  = (state == S_PUSH) && (!m_tvalid || m_tready);

  assign dx_new    = DX_W'(in_x) - DX_W'(held_x);
  assign dx_old    = DX_W'(held_x) - DX_W'(older_x);
  assign dx_new_ok = !dx_new[DX_W-1] && (|dx_new);
  assign dx_old_ok = !dx_old[DX_W-1] && (|dx_old);
  assign dx_sum    = {1'b0, dx_old} + {1'b0, dx_new};
  assign vol_mag   = held_vol[DATA_W-1] ? DATA_W'(-held_vol) : held_vol;
  assign d_neg     = -d_val;

  // operand selection for the shared divider
  always_comb begin
    num     = '0;
    use_sq  = 1'b0;
    den_sel = '0;
    case (state)
      S_DIV_F: begin
        num     = held_drift[DATA_W-1] ? '0 : held_drift;
        den_sel = DEN_W'(dx_new[DATA_W-1:0]);
      end
      S_DIV_D: begin
        use_sq  = 1'b1;
        den_sel = prod;
      end
      S_DIV_G: begin
        num     = held_drift;
        den_sel = DEN_W'(dx_sum);
      end
      S_DIV_T: begin
        num     = held_drift;
        den_sel = (dir == DIR_FWD) ? DEN_W'(dx_new[DATA_W-1:0])
                                   : DEN_W'(dx_old[DATA_W-1:0]);
      end
      S_DIV_L: begin
        num     = in_al[DATA_W-1] ? in_al : '0;
        den_sel = DEN_W'(dx_new[DATA_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  assign num_neg   = num[DATA_W-1];
  assign num_mag   = num_neg ? DATA_W'(-num) : num;
  assign dividend  = use_sq ? {sq, {(FRAC_BITS-1){1'b0}}}
                            : {num_mag, {(DVD_W-DATA_W){1'b0}}};
  assign nbits     = use_sq ? CNT_W'(DVD_W) : CNT_W'(QD_BITS);
  assign div_state = (state == S_DIV_F) || (state == S_DIV_D) || (state == S_DIV_G) ||
                     (state == S_DIV_T) || (state == S_DIV_L);
  assign div_start = div_state && !launched;
  assign qv        = qsat(num_neg, dres.over, dres.quot);

  assign mul_en = (state == S_SQ) || (state == S_PROD);
  assign mul_a  = (state == S_SQ) ? vol_mag : dx_new[DATA_W-1:0];
  assign mul_b  = (state == S_SQ) ? vol_mag : dx_old[DATA_W-1:0];

  ust_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .nbits    (nbits),
    .divisor  (den_sel),
    .res      (dres)
  );

  ust_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      after_push  <= S_IDLE;
      launched    <= 1'b0;
      points_seen <= PS_START;
      older_x     <= '0;
      held_x      <= '0;
      held_drift  <= '0;
      held_vol    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (push_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (div_start) begin
        launched <= 1'b1;
      end else if (div_state && dres.done) begin
        launched <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_x   <= s_tdata[DATA_W-1:0];
            in_al  <= s_tdata[2*DATA_W-1:DATA_W];
            in_be  <= s_tdata[3*DATA_W-1:2*DATA_W];
            in_fin <= s_tlast;
            state  <= S_DISP;
          end
        end

        S_DISP: begin
          r_a    <= '0;
          r_b    <= '0;
          r_c    <= '0;
          r_bad  <= 1'b1;
          r_last <= (points_seen == PS_START) && in_fin;
          case (points_seen)
            PS_START: begin
              if (in_fin) begin
                // lone final point: flagged stencil, window untouched
                after_push <= S_IDLE;
                state      <= S_PUSH;
              end else begin
                held_x      <= in_x;
                held_drift  <= in_al;
                held_vol    <= in_be;
                points_seen <= PS_FIRST;
                state       <= S_IDLE;
              end
            end
            PS_FIRST: begin
              after_push <= S_CHKL;
              state      <= dx_new_ok ? S_DIV_F : S_PUSH;
            end
            default: begin
              after_push <= S_CHKL;
              state      <= (dx_new_ok && dx_old_ok) ? S_SQ : S_PUSH;
            end
          endcase
        end

        S_DIV_F: begin
          if (launched && dres.done) begin
            r_a        <= '0;
            r_b        <= sub48('0, qv);
            r_c        <= qv;
            r_last     <= 1'b0;
            r_bad      <= 1'b0;
            after_push <= S_CHKL;
            state      <= S_PUSH;
          end
        end

        S_SQ: begin
          state <= S_PROD;
        end

        S_PROD: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_DIV_D;
        end

        S_DIV_D: begin
          if (launched && dres.done) begin
            d_val <= qv;
            state <= S_DIV_G;
          end
        end

        S_DIV_G: begin
          b0_val <= sub48(d_neg, d_val);
          if (launched && dres.done) begin
            g_val <= qv;
            if (qv > d_val) begin
              dir   <= DIR_FWD;
              state <= S_DIV_T;
            end else if (qv < d_neg) begin
              dir   <= DIR_BWD;
              state <= S_DIV_T;
            end else begin
              dir   <= DIR_CEN;
              state <= S_COMB;
            end
          end
        end

        S_DIV_T: begin
          if (launched && dres.done) begin
            t_val <= qv;
            state <= S_COMB;
          end
        end

        S_COMB: begin
          case (dir)
            DIR_FWD: begin
              r_a <= d_val;
              r_b <= sub48(b0_val, t_val);
              r_c <= add48(d_val, t_val);
            end
            DIR_BWD: begin
              r_a <= sub48(d_val, t_val);
              r_b <= add48(b0_val, t_val);
              r_c <= d_val;
            end
            default: begin
              r_a <= sub48(d_val, g_val);
              r_b <= b0_val;
              r_c <= add48(d_val, g_val);
            end
          endcase
          r_last     <= 1'b0;
          r_bad      <= 1'b0;
          after_push <= S_CHKL;
          state      <= S_PUSH;
        end

        S_PUSH: begin
          // wait for the output register to free up
          if (push_go) begin
            m_tdata  <= {r_c, r_b, r_a};
            m_tlast  <= r_last;
            m_tuser  <= r_bad;
            state    <= after_push;
          end
        end

        S_CHKL: begin
          if (!in_fin) begin
            state <= S_UPD;
          end else if (dx_new_ok) begin
            state <= S_DIV_L;
          end else begin
            r_a        <= '0;
            r_b        <= '0;
            r_c        <= '0;
            r_last     <= 1'b1;
            r_bad      <= 1'b1;
            after_push <= S_UPD;
            state      <= S_PUSH;
          end
        end

        S_DIV_L: begin
          if (launched && dres.done) begin
            r_a        <= sub48('0, qv);
            r_b        <= qv;
            r_c        <= '0;
            r_last     <= 1'b1;
            r_bad      <= 1'b0;
            after_push <= S_UPD;
            state      <= S_PUSH;
          end
        end

        S_UPD: begin
          // advance the window
          older_x     <= held_x;
          held_x      <= in_x;
          held_drift  <= in_al;
          held_vol    <= in_be;
          points_seen <= in_fin ? PS_START : PS_INNER;
          state       <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ust_checker.sv
// Port-level checker for the upwind stencil builder, bound to the top level.
// Depends on ust_pkg for the stream widths.
`timescale 1ns / 1ps
`default_nettype none

module ust_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ust_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tlast,
  input logic [0:0]                    m_tuser
);
  import ust_pkg::*;

  // stalled output transaction stays put
  a_m_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_m_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("m_ payload changed while stalled");

  // one point at a time: the sequencer leaves idle on every input transaction
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second point taken while busy");

  // a flagged stencil carries no weights
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("bad-grid stencil with nonzero weights");

  // the backward stencil of the final point has no upper weight
  a_last_upper: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[M_DATA_W-1:2*COEF_W] == '0)
    else $error("last stencil with nonzero upper weight");

endmodule

bind upwind_stencil_builder ust_checker u_ust_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/upwind_stencil_builder_tb.sv
// Self-checking testbench for upwind_stencil_builder: streams grids of points,
// predicts each tridiagonal stencil in fixed point and checks every result.
// Depends on ust_pkg and the design sources of upwind_stencil_builder.
`timescale 1ns / 1ps

module upwind_stencil_builder_tb;

  localparam int     FRAC        = ust_pkg::FRAC_BITS_DEF;
  localparam int     N_POINTS    = 1750;
  localparam int     HOLD_CYCLES = 2500;
  localparam int     DRAIN_WAIT  = 400;
  localparam int     PRINT_LIMIT = 40;
  localparam longint COEF_HI     = 64'sd140737488355327;
  localparam longint COEF_LO     = -COEF_HI - 1;
  localparam logic [31:0] ONE    = 32'h0001_0000;

  typedef struct {
    logic [47:0] lower;
    logic [47:0] centre;
    logic [47:0] upper;
    logic        last;
    logic        bad;
  } stencil_t;

  class stencil_scoreboard;
    stencil_t    pending[$];
    int          errors;
    longint      older_x;
    longint      held_x;
    longint      held_drift;
    longint      held_vol;
    int unsigned grid_fill;

    function new();
      errors    = 0;
      older_x   = 0;
      held_x    = 0;
      held_drift = 0;
      held_vol  = 0;
      grid_fill = 0;
    endfunction

    function longint clamp48(longint v);
      if (v > COEF_HI) return COEF_HI;
      if (v < COEF_LO) return COEF_LO;
      return v;
    endfunction

    // (num * 2^F) / den, truncated toward zero; den is positive
    function longint ratio_q(longint num, longint den);
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] lim;
      bit          neg;
      lim = COEF_HI;
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (mag << FRAC) / den;
      if (neg) return (q > lim + 64'd1) ? COEF_LO : -longint'(q);
      return (q > lim) ? COEF_HI : longint'(q);
    endfunction

    // floor(beta^2 * 2^(F-1) / (dxp * dxm)), saturated
    function longint diffusion_q(longint beta, longint dxp, longint dxm);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic [63:0]  mag;
      mag = (beta < 0) ? -beta : beta;
      num = {64'd0, mag} * {64'd0, mag};
      num = num << (FRAC - 1);
      den = {64'd0, 64'(dxp)} * {64'd0, 64'(dxm)};
      q   = num / den;
      if (q > 128'(COEF_HI)) return COEF_HI;
      return longint'(q[63:0]);
    endfunction

    function void push(longint a, longint b, longint c, bit last, bit bad);
      stencil_t s;
      s.lower  = a[47:0];
      s.centre = b[47:0];
      s.upper  = c[47:0];
      s.last   = last;
      s.bad    = bad;
      pending.push_back(s);
    endfunction

    function void interior(longint alpha, longint beta, longint dxm, longint dxp);
      longint d, a, b, c, g, t;
      if (dxm <= 0 || dxp <= 0) begin
        push(0, 0, 0, 0, 1);
        return;
      end
      d = diffusion_q(beta, dxp, dxm);
      a = d;
      b = clamp48(-2 * d);
      c = d;
      g = ratio_q(alpha, dxp + dxm);
      if (g > d) begin
        t = ratio_q(alpha, dxp);
        b = clamp48(b - t);
        c = clamp48(c + t);
      end else if (g < -d) begin
        t = ratio_q(alpha, dxm);
        a = clamp48(a - t);
        b = clamp48(b + t);
      end else begin
        a = clamp48(a - g);
        c = clamp48(c + g);
      end
      push(a, b, c, 0, 0);
    endfunction

    // Advance the point window on an accepted input transaction
    function void take_point(logic [31:0] x_raw, logic [31:0] drift_raw,
                             logic [31:0] vol_raw, logic fin);
      longint x, al, be, dx, q;
      x  = longint'($signed(x_raw));
      al = longint'($signed(drift_raw));
      be = longint'($signed(vol_raw));
      if (grid_fill == 0) begin
        if (fin) begin
          push(0, 0, 0, 1, 1);
          return;
        end
        held_x     = x;
        held_drift = al;
        held_vol   = be;
        grid_fill  = 1;
        return;
      end
      dx = x - held_x;
      if (grid_fill == 1) begin
        if (dx <= 0) begin
          push(0, 0, 0, 0, 1);
        end else begin
          q = ratio_q((held_drift > 0) ? held_drift : 0, dx);
          push(0, clamp48(-q), q, 0, 0);
        end
      end else begin
        interior(held_drift, held_vol, held_x - older_x, dx);
      end
      if (fin) begin
        if (dx <= 0) begin
          push(0, 0, 0, 1, 1);
        end else begin
          q = ratio_q((al < 0) ? al : 0, dx);
          push(clamp48(-q), q, 0, 1, 0);
        end
        grid_fill = 0;
      end else begin
        grid_fill = 2;
      end
      older_x    = held_x;
      held_x     = x;
      held_drift = al;
      held_vol   = be;
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_stencil(logic [143:0] data, logic last, logic bad);
      stencil_t e;
      if (pending.size() == 0) begin
        report($sformatf("stencil %h with nothing expected", data));
        return;
      end
      e = pending.pop_front();
      if (data[47:0] !== e.lower)
        report($sformatf("coef_lower %h, expected %h", data[47:0], e.lower));
      if (data[95:48] !== e.centre)
        report($sformatf("coef_centre %h, expected %h", data[95:48], e.centre));
      if (data[143:96] !== e.upper)
        report($sformatf("coef_upper %h, expected %h", data[143:96], e.upper));
      if (last !== e.last)
        report($sformatf("last_stencil %b, expected %b", last, e.last));
      if (bad !== e.bad)
        report($sformatf("bad_grid %b, expected %b", bad, e.bad));
    endtask
  endclass

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata  = '0;  // grid_x, drift, volatility
  logic         s_tlast  = 1'b0; // final_point
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;        // coef_lower, coef_centre, coef_upper
  logic         m_tlast;        // last_stencil
  logic [0:0]   m_tuser;        // bad_grid

  stencil_scoreboard sb = new();
  int gap_pct     = 25;
  int stall_pct   = 25;
  bit hold_req    = 1'b0;
  int points_sent = 0;

  upwind_stencil_builder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(64'd15_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random short stalls, one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_stencil(m_tdata, m_tlast, m_tuser[0]);
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] drift,
                            input logic [31:0] vol, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= {vol, drift, x};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.take_point(x, drift, vol, fin);
    points_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Random word over every scale, both signs
  function automatic logic [31:0] scaled_word();
    logic [31:0] w;
    w = $urandom;
    return $signed(w) >>> $urandom_range(0, 31);
  endfunction

  task automatic random_grid(input int len);
    logic [31:0] x;
    logic [31:0] step;
    int          pick;
    x = $signed($urandom) >>> $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          step = '0;
        end else if (pick < 6) begin
          step = -($urandom >> $urandom_range(8, 31));
        end else begin
          step = $urandom >> $urandom_range(2, 31);
        end
        x = x + step;
      end
      send_point(x, scaled_word(), scaled_word(), i == len - 1);
    end
  endtask

  initial begin
    int  len;
    bit  pressure_done;
    pressure_done = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);

    // one-point grid
    send_point(32'h0000_1234, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // two points, unit raw spacing, extreme drifts
    send_point(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // widest spacings across the whole coordinate range
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // repeated coordinate: zero spacing
    send_point(32'h0000_0005, ONE, ONE, 1'b0);
    send_point(32'h0000_0005, ONE, ONE, 1'b0);
    send_point(32'h0000_000A, -ONE, ONE, 1'b1);
    // coordinate going backward
    send_point(32'h0000_0000, ONE, ONE, 1'b0);
    send_point(32'h0000_0064, ONE, ONE, 1'b0);
    send_point(32'h0000_0032, -ONE, ONE, 1'b1);
    // forward, backward, central, saturated diffusion
    send_point(32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 1'b0);
    send_point(ONE,           32'h0008_0000, 32'h0000_8000, 1'b0);
    send_point(2 * ONE,       32'hFFF8_0000, 32'h0000_8000, 1'b0);
    send_point(3 * ONE,       32'h0000_4000, ONE,           1'b0);
    send_point(4 * ONE,       32'h0000_028F, 32'h7FFF_FFFF, 1'b0);
    send_point(4 * ONE + 1,   32'hFFF8_0000, ONE,           1'b1);

    while (points_sent < N_POINTS) begin
      if (!pressure_done && points_sent >= 600) begin
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if (points_sent >= 1500 || (points_sent >= 1050 && points_sent < 1250)) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 25;
        stall_pct = 25;
      end
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(9, 24);
      if (points_sent + len > N_POINTS) len = N_POINTS - points_sent;
      random_grid(len);
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
